// ===== design/qyh_pkg.sv =====
// ----------------------------------------------------------------------------
// qyh_pkg
// Types, constants and tables shared by the quaternion yaw heading tracker.
// ----------------------------------------------------------------------------
package qyh_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SETUP,
        ST_CORDIC,
        ST_YAW,
        ST_WRAP,
        ST_ZERO,
        ST_CDEG,
        ST_DONE
    } qyh_state_t;

    typedef enum logic [1:0] {
        KIND_ROT   = 2'd0,
        KIND_ZERO  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_OTHER = 2'd3
    } qyh_kind_t;

    typedef enum logic {
        CFG_YAW_NEGATE = 1'b0,
        CFG_TIMEOUT_MS = 1'b1
    } qyh_cfg_idx_t;

    localparam int MAX_STEPS = 24;
    localparam int STEP_W    = 5;

    localparam logic signed [16:0] PI_Q13      = 17'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [20:0] PI_Q16      = 21'sd205887;
    localparam logic signed [16:0] CENTIDEG_K  = 17'sd45837;
    localparam logic signed [36:0] ONE_Q28     = 37'sd268435456;
    localparam logic signed [33:0] CDEG_ROUND  = 34'sd32768;
    localparam logic [15:0]        TIMEOUT_RST = 16'd100;
    localparam logic [15:0]        MS_MAX      = 16'hffff;

    // atan(2^-s) in q16 radians
    function automatic logic [15:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30385;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // single fold back into [-pi, pi], input lies within [-2pi, 2pi]
    function automatic logic signed [15:0] wrap_pi(input logic signed [17:0] a);
        logic signed [17:0] w;
        if (a > 18'(PI_Q13))
            w = a - TWO_PI_Q13;
        else if (a < -18'(PI_Q13))
            w = a + TWO_PI_Q13;
        else
            w = a;
        return w[15:0];
    endfunction

endpackage

// ===== design/qyh_report_if.sv =====
// ----------------------------------------------------------------------------
// qyh_report_if
// Input channel: one report beat with its kind and quaternion parts.
// ----------------------------------------------------------------------------
interface qyh_report_if;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] quat_real;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;

    modport source
    (
        output valid,
        output kind,
        output quat_real,
        output quat_i,
        output quat_j,
        output quat_k,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  kind,
        input  quat_real,
        input  quat_i,
        input  quat_j,
        input  quat_k,
        output ready
    );

endinterface

// ===== design/qyh_status_if.sv =====
// ----------------------------------------------------------------------------
// qyh_status_if
// Output channel: one status beat with heading and sensor health.
// ----------------------------------------------------------------------------
interface qyh_status_if;

    logic               valid;
    logic               ready;
    logic               new_heading;
    logic signed [15:0] heading_angle;
    logic signed [15:0] heading_centideg;
    logic               healthy;

    modport source
    (
        output valid,
        output new_heading,
        output heading_angle,
        output heading_centideg,
        output healthy,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  new_heading,
        input  heading_angle,
        input  heading_centideg,
        input  healthy,
        output ready
    );

endinterface

// ===== design/quaternion_yaw_heading_tracker.sv =====
// ----------------------------------------------------------------------------
// quaternion_yaw_heading_tracker
// Rotation sample: states MUL, SETUP, CORDIC (CORDIC_STEPS iterations, capped at
// MAX_STEPS), YAW, WRAP, CDEG, DONE. Zero heading: ZERO, CDEG, DONE; tick and other
// reports: CDEG, DONE. One report at a time, the next taken in the same cycle that
// result valid rises, also while that result still waits; the multiplier is shared.
// Reset: heading, zero offset and tick count cleared, no mount negation,
// timeout 100 ms.
// ----------------------------------------------------------------------------
module quaternion_yaw_heading_tracker
    import qyh_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata,
    qyh_report_if.sink   report,
    qyh_status_if.source status
);

    localparam int STEPS_USED = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_USED - 1);

    // control and state registers
    qyh_state_t         state_reg, state_next;
    logic               negate_reg, negate_next;
    logic [15:0]        timeout_reg, timeout_next;
    logic signed [15:0] heading_reg, heading_next;
    logic signed [15:0] offset_reg, offset_next;
    logic [15:0]        ms_reg, ms_next;
    logic [2:0]         mcnt_reg, mcnt_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic               fresh_reg, fresh_next;
    logic signed [15:0] qr_reg, qi_reg, qj_reg, qk_reg;
    logic signed [33:0] prod_reg;
    logic signed [32:0] num_reg, num_next;
    logic signed [32:0] sq_reg, sq_next;
    logic signed [36:0] x_reg, x_next;
    logic signed [36:0] y_reg, y_next;
    logic signed [20:0] z_reg, z_next;
    logic               zero_reg, zero_next;
    logic signed [16:0] yaw_reg, yaw_next;
    logic               out_new_reg;
    logic signed [15:0] out_angle_reg;
    logic signed [15:0] out_cdeg_reg;
    logic               out_healthy_reg;

    // control decode
    logic               accept;
    logic               mul_en;
    logic               out_load;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;

    // datapath temporaries
    logic signed [36:0] x0, y0, dx, dy;
    logic signed [20:0] tab, z_rnd;
    logic signed [16:0] yaw_c;
    logic signed [33:0] cd_full;

    assign accept       = report.valid && report.ready;
    assign mul_p        = 34'(mul_a) * 34'(mul_b);
    assign cd_full      = (prod_reg + CDEG_ROUND) >>> 16;

    assign status.valid            = out_valid_reg;
    assign status.new_heading      = out_new_reg;
    assign status.heading_angle    = out_angle_reg;
    assign status.heading_centideg = out_cdeg_reg;
    assign status.healthy          = out_healthy_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (qyh_kind_t'(report.kind))
                        KIND_ROT:   state_next = ST_MUL;
                        KIND_ZERO:  state_next = ST_ZERO;
                        KIND_TICK:  state_next = ST_CDEG;
                        KIND_OTHER: state_next = ST_CDEG;
                    endcase
                end
            end
            ST_MUL:
            begin
                if (mcnt_reg == 3'd4)
                    state_next = ST_SETUP;
            end
            ST_SETUP:  state_next = ST_CORDIC;
            ST_CORDIC:
            begin
                if (step_reg == LAST_STEP)
                    state_next = ST_YAW;
            end
            ST_YAW:    state_next = ST_WRAP;
            ST_WRAP:   state_next = ST_CDEG;
            ST_ZERO:   state_next = ST_CDEG;
            ST_CDEG:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb
    begin
        report.ready = 1'b0;
        mul_en       = 1'b0;
        out_load     = 1'b0;
        mul_a        = 17'(qr_reg);
        mul_b        = 17'(qk_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                report.ready = 1'b1;
            end
            ST_MUL:
            begin
                mul_en = 1'b1;
                case (mcnt_reg)
                    3'd0:
                    begin
                        mul_a = 17'(qr_reg);
                        mul_b = 17'(qk_reg);
                    end
                    3'd1:
                    begin
                        mul_a = 17'(qi_reg);
                        mul_b = 17'(qj_reg);
                    end
                    3'd2:
                    begin
                        mul_a = 17'(qj_reg);
                        mul_b = 17'(qj_reg);
                    end
                    default:
                    begin
                        mul_a = 17'(qk_reg);
                        mul_b = 17'(qk_reg);
                    end
                endcase
            end
            ST_CDEG:
            begin
                mul_en = 1'b1;
                mul_a  = 17'(heading_reg);
                mul_b  = CENTIDEG_K;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || status.ready;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        negate_next    = negate_reg;
        timeout_next   = timeout_reg;
        heading_next   = heading_reg;
        offset_next    = offset_reg;
        ms_next        = ms_reg;
        mcnt_next      = mcnt_reg;
        step_next      = step_reg;
        fresh_next     = fresh_reg;
        num_next       = num_reg;
        sq_next        = sq_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zero_next      = zero_reg;
        yaw_next       = yaw_reg;
        out_valid_next = out_valid_reg;

        x0    = ONE_Q28 - (37'(sq_reg) <<< 1);
        y0    = 37'(num_reg) <<< 1;
        dx    = y_reg >>> step_reg;
        dy    = x_reg >>> step_reg;
        tab   = 21'(atan_entry(step_reg));
        z_rnd = (z_reg + 21'sd4) >>> 3;
        yaw_c = z_rnd[16:0];

        if (cfg_we)
        begin
            unique case (qyh_cfg_idx_t'(cfg_index))
                CFG_YAW_NEGATE: negate_next  = cfg_wdata[0];
                CFG_TIMEOUT_MS: timeout_next = cfg_wdata;
            endcase
        end

        if (status.ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fresh_next = (qyh_kind_t'(report.kind) == KIND_ROT);
                    mcnt_next  = 3'd0;
                    num_next   = '0;
                    sq_next    = '0;
                    case (qyh_kind_t'(report.kind))
                        KIND_ROT:
                        begin
                            ms_next = '0;
                        end
                        KIND_TICK:
                        begin
                            if (ms_reg != MS_MAX)
                                ms_next = ms_reg + 16'd1;
                        end
                        default:
                        begin
                            ms_next = ms_reg;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                mcnt_next = mcnt_reg + 3'd1;
                if (mcnt_reg == 3'd1 || mcnt_reg == 3'd2)
                    num_next = num_reg + prod_reg[32:0];
                if (mcnt_reg == 3'd3 || mcnt_reg == 3'd4)
                    sq_next = sq_reg + prod_reg[32:0];
            end
            ST_SETUP:
            begin
                step_next = '0;
                zero_next = (x0 == '0) && (y0 == '0);
                if (x0 < 0)
                begin
                    z_next = (y0 >= 0) ? PI_Q16 : -PI_Q16;
                    x_next = -x0;
                    y_next = -y0;
                end
                else
                begin
                    z_next = '0;
                    x_next = x0;
                    y_next = y0;
                end
            end
            ST_CORDIC:
            begin
                step_next = step_reg + 1'b1;
                if (y_reg >= 0)
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + tab;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - tab;
                end
            end
            ST_YAW:
            begin
                // clamp overshoot to +/-pi, zero vector gives zero
                if (z_rnd > 21'(PI_Q13))
                    yaw_c = PI_Q13;
                else if (z_rnd < -21'(PI_Q13))
                    yaw_c = -PI_Q13;
                if (zero_reg)
                    yaw_c = '0;
                yaw_next = negate_reg ? -yaw_c : yaw_c;
            end
            ST_WRAP:
            begin
                heading_next = wrap_pi(18'(yaw_reg) - 18'(offset_reg));
            end
            ST_ZERO:
            begin
                offset_next  = wrap_pi(18'(offset_reg) + 18'(heading_reg));
                heading_next = '0;
            end
            default:
            begin
                yaw_next = yaw_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            negate_reg    <= 1'b0;
            timeout_reg   <= TIMEOUT_RST;
            heading_reg   <= '0;
            offset_reg    <= '0;
            ms_reg        <= '0;
            mcnt_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            negate_reg    <= negate_next;
            timeout_reg   <= timeout_next;
            heading_reg   <= heading_next;
            offset_reg    <= offset_next;
            ms_reg        <= ms_next;
            mcnt_reg      <= mcnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fresh_reg <= fresh_next;
        num_reg   <= num_next;
        sq_reg    <= sq_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        zero_reg  <= zero_next;
        yaw_reg   <= yaw_next;
        if (accept)
        begin
            qr_reg <= report.quat_real;
            qi_reg <= report.quat_i;
            qj_reg <= report.quat_j;
            qk_reg <= report.quat_k;
        end
        if (mul_en)
            prod_reg <= mul_p;
        if (out_load)
        begin
            out_new_reg     <= fresh_reg;
            out_angle_reg   <= heading_reg;
            out_cdeg_reg    <= cd_full[15:0];
            out_healthy_reg <= (ms_reg < timeout_reg);
        end
    end

endmodule
